// ----- hw/rtl/bbfci_pkg.sv -----
`timescale 1ns / 1ps

package bbfci_pkg;

    // fixed field widths
    localparam int ADDR_W = 17;
    localparam int DATA_W = 8;

    // array geometry defaults
    localparam int ARRAY_BYTES_DEF   = 131072;
    localparam int PARAM_BLOCK_BYTES = 4096;

    // command bytes
    localparam logic [DATA_W-1:0] OP_READ_ARRAY    = 8'hFF;
    localparam logic [DATA_W-1:0] OP_READ_ID       = 8'h90;
    localparam logic [DATA_W-1:0] OP_READ_STATUS   = 8'h70;
    localparam logic [DATA_W-1:0] OP_CLEAR_STATUS  = 8'h50;
    localparam logic [DATA_W-1:0] OP_ERASE_SETUP   = 8'h20;
    localparam logic [DATA_W-1:0] OP_ERASE_CONFIRM = 8'hD0;
    localparam logic [DATA_W-1:0] OP_PROGRAM_SETUP = 8'h40;

    // register view values
    localparam logic [DATA_W-1:0] ID_EVEN     = 8'h89;
    localparam logic [DATA_W-1:0] ID_ODD      = 8'h94;
    localparam logic [DATA_W-1:0] STATUS_DONE = 8'h80;
    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    // address map
    localparam logic [ADDR_W-1:0] BLK_MASK      = 17'h1F000;
    localparam logic [ADDR_W-1:0] BOOT_MASK     = 17'h1E000;
    localparam logic [ADDR_W-1:0] BOOT_BASE     = 17'h0E000;
    localparam logic [ADDR_W-1:0] PARAM0_BASE   = 17'h0C000;
    localparam logic [ADDR_W-1:0] PARAM1_BASE   = 17'h0D000;
    localparam logic [ADDR_W-1:0] UPPER_BASE    = 17'h10000;
    localparam logic [ADDR_W-1:0] MAIN_LOW_LAST = PARAM0_BASE - 17'h1;

    // fill sweep kinds
    typedef enum logic [2:0] {
        SW_IDLE = 3'b001,
        SW_SPAN = 3'b010,
        SW_MAIN = 3'b100
    } t_sweep;

endpackage

// ----- hw/rtl/boot_block_flash_command_interface_core.sv -----
`timescale 1ns / 1ps

// channel   valid     stall     payload
// request   i_valid   o_stall   i_req_type, i_addr, i_wdata
// response  o_valid   i_stall   o_rdata
//
// each word gives one response word on o_valid: the accepting edge reads the array
// ram into the response stage, then the output register loads it unless i_stall holds it
// reads and writes are taken one per cycle through the single ram port while o_stall is low
// after reset a fill pass writes 0xff to all ARRAY_BYTES bytes, stalling requests
// an erase confirm stalls requests for its sweep: the 4096 bytes of a parameter block, or the main
// blocks (ARRAY_BYTES - 16384 bytes past 64 KiB); a held response admits one more

module boot_block_flash_command_interface_core
    import bbfci_pkg::*;
#(
    parameter int ARRAY_BYTES = ARRAY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int AW = $clog2(ARRAY_BYTES);
    localparam logic [ADDR_W:0]   ARRAY_LIM  = (ADDR_W+1)'(ARRAY_BYTES);
    localparam logic [ADDR_W-1:0] ARRAY_LAST = ADDR_W'(ARRAY_BYTES - 1);
    localparam logic [ADDR_W-1:0] PARAM_SPAN = ADDR_W'(PARAM_BLOCK_BYTES - 1);
    // main erase has an upper part only when the array reaches past 64 KiB
    localparam bit HAS_UPPER = (ARRAY_BYTES > 65536);

    // array ram, one port, registered read data
    logic [DATA_W-1:0] r_mem [ARRAY_BYTES];
    logic [DATA_W-1:0] r_mem_q;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_addr;
    logic [DATA_W-1:0] w_mem_wdata;

    // command state
    logic [DATA_W-1:0] r_cmd, n_cmd;
    logic [DATA_W-1:0] r_status, n_status;
    logic              r_view, n_view;

    // fill sweep
    t_sweep            r_sweep, n_sweep;
    logic [ADDR_W-1:0] r_sweep_addr, n_sweep_addr;
    logic [ADDR_W-1:0] r_sweep_last, n_sweep_last;

    // response stage behind the ram read, and the output register
    logic              r_p1_valid;
    logic              r_p1_use_mem;
    logic [DATA_W-1:0] r_p1_rdata;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rdata;

    logic              w_accept;
    logic              w_out_free;
    logic              w_sweeping;
    logic [ADDR_W:0]   w_wrap;
    logic [AW-1:0]     w_idx;
    logic [ADDR_W-1:0] w_blk;
    logic              w_prog_we;
    logic              w_start_main;
    logic              w_start_param;
    logic              w_rsp_use_mem;
    logic [DATA_W-1:0] w_rsp_rdata;

    assign w_sweeping = (r_sweep != SW_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = w_sweeping || (r_p1_valid && !w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign o_valid    = r_out_valid;
    assign o_rdata    = r_out_rdata;

    // addr modulo array size: addr is below twice the array size
    assign w_wrap = ({1'b0, i_addr} >= ARRAY_LIM) ? ({1'b0, i_addr} - ARRAY_LIM)
                                                  : {1'b0, i_addr};
    assign w_idx  = w_wrap[AW-1:0];
    assign w_blk  = i_addr & BLK_MASK;

    // command decode for the accepted word
    always_comb begin
        n_cmd         = r_cmd;
        n_status      = r_status;
        n_view        = r_view;
        w_prog_we     = 1'b0;
        w_start_main  = 1'b0;
        w_start_param = 1'b0;
        w_rsp_use_mem = 1'b0;
        w_rsp_rdata   = '0;
        if (w_accept) begin
            if (i_req_type) begin
                case (r_cmd)
                    OP_ERASE_SETUP: begin
                        if (i_wdata == OP_ERASE_CONFIRM) begin
                            // boot block: nothing erased, status still set
                            if (w_blk == PARAM0_BASE || w_blk == PARAM1_BASE) begin
                                w_start_param = 1'b1;
                            end else if (w_blk < PARAM0_BASE || w_blk >= UPPER_BASE) begin
                                w_start_main = 1'b1;
                            end
                            n_status = STATUS_DONE;
                        end
                        n_cmd = OP_READ_STATUS;
                    end
                    OP_PROGRAM_SETUP: begin
                        w_prog_we = ((i_addr & BOOT_MASK) != BOOT_BASE);
                        n_cmd     = OP_READ_STATUS;
                        n_status  = STATUS_DONE;
                    end
                    default: begin
                        n_cmd = i_wdata;
                        if (i_wdata == OP_CLEAR_STATUS) begin
                            n_status = '0;
                        end else if (i_wdata == OP_READ_ID || i_wdata == OP_READ_STATUS) begin
                            n_view = 1'b1;
                        end else if (i_wdata == OP_READ_ARRAY) begin
                            n_view = 1'b0;
                        end
                    end
                endcase
            end else if (!r_view) begin
                w_rsp_use_mem = 1'b1;
            end else if (r_cmd == OP_READ_ID) begin
                w_rsp_rdata = i_addr[0] ? ID_ODD : ID_EVEN;
            end else begin
                w_rsp_rdata = r_status;
            end
        end
    end

    // sweep sequencing; main erase skips the parameter and boot blocks
    always_comb begin
        n_sweep      = r_sweep;
        n_sweep_addr = r_sweep_addr;
        n_sweep_last = r_sweep_last;
        case (r_sweep)
            SW_IDLE: begin
                if (w_start_param) begin
                    n_sweep      = SW_SPAN;
                    n_sweep_addr = w_blk;
                    n_sweep_last = w_blk + PARAM_SPAN;
                end else if (w_start_main) begin
                    n_sweep      = SW_MAIN;
                    n_sweep_addr = '0;
                    n_sweep_last = ARRAY_LAST;
                end
            end
            SW_SPAN: begin
                if (r_sweep_addr == r_sweep_last) begin
                    n_sweep = SW_IDLE;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end
            SW_MAIN: begin
                if (r_sweep_addr == r_sweep_last ||
                    (r_sweep_addr == MAIN_LOW_LAST && !HAS_UPPER)) begin
                    n_sweep = SW_IDLE;
                end else if (r_sweep_addr == MAIN_LOW_LAST) begin
                    n_sweep_addr = UPPER_BASE;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end
            default: begin
                n_sweep = SW_IDLE;
            end
        endcase
    end

    // ram port: the sweep owns it while active, no word is accepted then
    assign w_mem_we    = w_sweeping || w_prog_we;
    assign w_mem_re    = w_accept && !i_req_type;
    assign w_mem_addr  = w_sweeping ? r_sweep_addr[AW-1:0] : w_idx;
    assign w_mem_wdata = w_sweeping ? ERASED_BYTE : i_wdata;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_mem_addr];
        end
    end

    // control registers; reset starts the full fill pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= OP_READ_ARRAY;
            r_status     <= '0;
            r_view       <= 1'b0;
            r_sweep      <= SW_SPAN;
            r_sweep_addr <= '0;
            r_sweep_last <= ARRAY_LAST;
            r_p1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cmd        <= n_cmd;
            r_status     <= n_status;
            r_view       <= n_view;
            r_sweep      <= n_sweep;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_last <= n_sweep_last;
            if (w_accept) begin
                r_p1_valid <= 1'b1;
            end else if (w_out_free) begin
                r_p1_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_p1_valid;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_use_mem <= w_rsp_use_mem;
            r_p1_rdata   <= w_rsp_rdata;
        end
        if (w_out_free) begin
            r_out_rdata <= r_p1_use_mem ? r_mem_q : r_p1_rdata;
        end
    end

    // main erase never writes the parameter or boot blocks
    a_main_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sweep == SW_MAIN) |-> (r_sweep_addr < PARAM0_BASE || r_sweep_addr >= UPPER_BASE))
        else $error("main erase inside parameter or boot block");

    // sweep address never runs past its end
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sweep != SW_IDLE) |-> (r_sweep_addr <= r_sweep_last))
        else $error("sweep address past end");

    // an accepted word always lands in the response stage
    a_accept_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_p1_valid)
        else $error("accepted word lost");

    // a response held behind a stalled output is kept
    a_p1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && r_out_valid && i_stall) |=> (r_p1_valid && r_out_valid))
        else $error("held response dropped");

endmodule

// ----- tb/flash_bus_checker.sv -----
`timescale 1ns / 1ps

module flash_bus_checker
    import bbfci_pkg::*;
#(
    parameter int ARRAY_BYTES = ARRAY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_stall,
    input  logic              i_req_type,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_stall,
    input  logic [DATA_W-1:0] i_rdata,
    output int                o_fail_count,
    output int                o_outstanding
);

    typedef struct packed {
        logic              is_read;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] rdata;
    } t_pending_word;

    // shadow of the device state
    logic [DATA_W-1:0] cmd_byte;
    logic [DATA_W-1:0] status_byte;
    logic              reg_view;
    logic [DATA_W-1:0] flash_mem [ARRAY_BYTES];

    t_pending_word pending_words[$];
    int            fail_tally;

    function automatic void fill_erased(input int unsigned start, input int unsigned len);
        for (int unsigned i = start; i < start + len && i < ARRAY_BYTES; i++) begin
            flash_mem[i] = ERASED_BYTE;
        end
    endfunction

    // applies one bus word to the shadow state, returns the read data it gives
    function automatic logic [DATA_W-1:0] bus_word_rdata(input logic wr,
                                                         input logic [ADDR_W-1:0] a,
                                                         input logic [DATA_W-1:0] d);
        logic [ADDR_W-1:0] blk;
        logic [DATA_W-1:0] rd;
        blk = a & BLK_MASK;
        rd  = '0;
        if (wr) begin
            case (cmd_byte)
                OP_ERASE_SETUP: begin
                    if (d == OP_ERASE_CONFIRM) begin
                        if (blk == PARAM0_BASE || blk == PARAM1_BASE) begin
                            fill_erased(blk, PARAM_BLOCK_BYTES);
                        end else if (blk < PARAM0_BASE || blk >= UPPER_BASE) begin
                            fill_erased(0, PARAM0_BASE);
                            fill_erased(UPPER_BASE, ARRAY_BYTES);
                        end
                        status_byte = STATUS_DONE;
                    end
                    cmd_byte = OP_READ_STATUS;
                end
                OP_PROGRAM_SETUP: begin
                    if ((a & BOOT_MASK) != BOOT_BASE) flash_mem[a % ARRAY_BYTES] = d;
                    cmd_byte    = OP_READ_STATUS;
                    status_byte = STATUS_DONE;
                end
                default: begin
                    cmd_byte = d;
                    if (d == OP_CLEAR_STATUS) status_byte = '0;
                    else if (d == OP_READ_ID || d == OP_READ_STATUS) reg_view = 1'b1;
                    else if (d == OP_READ_ARRAY) reg_view = 1'b0;
                end
            endcase
        end else if (!reg_view) begin
            rd = flash_mem[a % ARRAY_BYTES];
        end else if (cmd_byte == OP_READ_ID) begin
            rd = a[0] ? ID_ODD : ID_EVEN;
        end else begin
            rd = status_byte;
        end
        return rd;
    endfunction

    always @(posedge i_clk) begin
        t_pending_word head;
        if (!i_rst_n) begin
            cmd_byte    = OP_READ_ARRAY;
            status_byte = '0;
            reg_view    = 1'b0;
            fill_erased(0, ARRAY_BYTES);
            pending_words.delete();
            fail_tally = 0;
        end else begin
            // response first, so a word taken this edge is never matched to itself
            if (i_rsp_valid && !i_rsp_stall) begin
                if (pending_words.size() == 0) begin
                    fail_tally++;
                    $display("%0t: response word with none expected: expected none, got %02h",
                             $time, i_rdata);
                end else begin
                    head = pending_words.pop_front();
                    if (i_rdata !== head.rdata) begin
                        fail_tally++;
                        $display("%0t: rdata mismatch (%s %05h): expected %02h, got %02h",
                                 $time, head.is_read ? "read" : "write", head.addr,
                                 head.rdata, i_rdata);
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                head.is_read = !i_req_type;
                head.addr    = i_addr;
                head.rdata   = bus_word_rdata(i_req_type, i_addr, i_wdata);
                pending_words.push_back(head);
            end
        end
        o_fail_count  <= fail_tally;
        o_outstanding <= pending_words.size();
    end

endmodule

// ----- tb/tb_boot_block_flash_command_interface_core.sv -----
`timescale 1ns / 1ps

module tb_boot_block_flash_command_interface_core;
    import bbfci_pkg::*;

    localparam int RANDOM_WORDS = 950;
    // CYCLE_LIMIT covers the reset fill, three main erases, a few dozen block erases and
    // the stalls of about a thousand words
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_req_type;
    logic [ADDR_W-1:0] i_addr;
    logic [DATA_W-1:0] i_wdata;
    logic              o_valid;
    logic              i_stall;
    logic [DATA_W-1:0] o_rdata;

    int fail_count;
    int outstanding;

    // stimulus side bookkeeping
    logic [DATA_W-1:0] cmd_track;        // command latch as the sender sees it
    int                burst_left;
    int                words_sent;
    int                main_erases_left; // main erases are slow, keep them few
    bit                main_erase_ok;
    bit                hold_req;         // asks the receiver for one long hold-off
    logic [ADDR_W-1:0] hot_addr [24];    // addresses reused so reads see programs

    boot_block_flash_command_interface_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_addr     (i_addr),
        .i_wdata    (i_wdata),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rdata    (o_rdata)
    );

    flash_bus_checker bus_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_type    (i_req_type),
        .i_addr        (i_addr),
        .i_wdata       (i_wdata),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_rdata       (o_rdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly hot addresses, one in five anywhere in the 17-bit space
    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 4) == 0) return ADDR_W'($urandom);
        return hot_addr[$urandom_range(0, 23)];
    endfunction

    // offers one word at the falling edge, returns at the edge that takes it
    task automatic send_word(input logic wr, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
        logic [ADDR_W-1:0] blk;
        blk = a & BLK_MASK;
        if (wr) begin
            if (cmd_track == OP_ERASE_SETUP) begin
                // a confirm into the main blocks only when one is planned,
                // otherwise it lands on the lower parameter block
                if (d == OP_ERASE_CONFIRM && (blk < PARAM0_BASE || blk >= UPPER_BASE)) begin
                    if (main_erase_ok && main_erases_left > 0) main_erases_left--;
                    else a = PARAM0_BASE | (a & 17'h00FFF);
                end
                cmd_track = OP_READ_STATUS;
            end else if (cmd_track == OP_PROGRAM_SETUP) begin
                cmd_track = OP_READ_STATUS;
            end else begin
                cmd_track = d;
            end
        end
        main_erase_ok = 1'b0;
        @(negedge i_clk);
        // bursts of random length with idle gaps between them
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_valid    <= 1'b1;
        i_req_type <= wr;
        i_addr     <= a;
        i_wdata    <= d;
        burst_left--;
        words_sent++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // receiver stall pattern, changing character after each random span
    initial begin : rx_stall_pattern
        int mode;
        int span;
        int tick;
        bit hold_taken;
        tick       = 0;
        hold_taken = 1'b0;
        i_stall    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                if (hold_req && !hold_taken) begin
                    // long hold-off: block fills and stalls its input
                    hold_taken = 1'b1;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end else begin
                    case (mode)
                        0:       i_stall <= 1'b0;
                        1:       i_stall <= ($urandom_range(0, 3) == 0);
                        2:       i_stall <= ($urandom_range(0, 9) < 7);
                        default: i_stall <= ((tick % 5) < 2);
                    endcase
                end
            end
        end
    end

    // watchdog
    initial begin : cycle_watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("boot_block_flash_command_interface_core test failed");
        $finish;
    end

    initial begin : stimulus
        int                goal;
        int                r;
        bit                hold_done;
        bit                pause_done;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] cmd;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = 1'b0;
        i_addr     = '0;
        i_wdata    = '0;

        cmd_track        = OP_READ_ARRAY;
        burst_left       = 0;
        words_sent       = 0;
        main_erases_left = 3;
        main_erase_ok    = 1'b0;
        hold_req         = 1'b0;
        hold_done        = 1'b0;
        pause_done       = 1'b0;

        // hot pool spread over main low, both parameter blocks, boot, upper half
        for (int i = 0; i < 24; i++) begin
            case (i % 6)
                0:       hot_addr[i] = ADDR_W'($urandom_range(0, 'hBFFF));
                1:       hot_addr[i] = PARAM0_BASE + ADDR_W'($urandom_range(0, 'hFFF));
                2:       hot_addr[i] = PARAM1_BASE + ADDR_W'($urandom_range(0, 'hFFF));
                3:       hot_addr[i] = BOOT_BASE + ADDR_W'($urandom_range(0, 'h1FFF));
                4:       hot_addr[i] = ADDR_W'($urandom_range('h10000, 'h1FFFF));
                default: hot_addr[i] = ADDR_W'($urandom);
            endcase
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // program at the top address and read it back through the array view
        send_word(1'b1, 17'h00000, OP_PROGRAM_SETUP);
        send_word(1'b1, 17'h1FFFF, 8'h5A);
        send_word(1'b0, 17'h1FFFF, 8'h00);
        // program into the boot block is dropped but still sets status
        send_word(1'b1, 17'h1FFFF, OP_PROGRAM_SETUP);
        send_word(1'b1, 17'h0E123, 8'hA5);
        send_word(1'b0, 17'h0E123, 8'hFF);
        // status view, then clear status
        send_word(1'b1, 17'h00000, OP_READ_STATUS);
        send_word(1'b0, 17'h00000, 8'h00);
        send_word(1'b1, 17'h00000, OP_CLEAR_STATUS);
        send_word(1'b0, 17'h00000, 8'h00);
        // id bytes on odd and even addresses
        send_word(1'b1, 17'h00000, OP_READ_ID);
        send_word(1'b0, 17'h1FFFE, 8'h00);
        send_word(1'b0, 17'h00001, 8'h00);
        send_word(1'b1, 17'h00000, OP_READ_ARRAY);
        // program both parameter blocks, erase the lower one
        send_word(1'b1, 17'h00000, OP_PROGRAM_SETUP);
        send_word(1'b1, 17'h0C010, 8'h00);
        send_word(1'b1, 17'h00000, OP_PROGRAM_SETUP);
        send_word(1'b1, 17'h0D020, 8'h33);
        send_word(1'b1, 17'h00000, OP_ERASE_SETUP);
        send_word(1'b1, 17'h0CFFF, OP_ERASE_CONFIRM);
        send_word(1'b0, 17'h0C010, 8'h00);
        // erase setup then a wrong byte: cancelled
        send_word(1'b1, 17'h00000, OP_ERASE_SETUP);
        send_word(1'b1, 17'h0D000, 8'h11);
        // confirm into the boot block erases nothing
        send_word(1'b1, 17'h00000, OP_ERASE_SETUP);
        send_word(1'b1, 17'h0F000, OP_ERASE_CONFIRM);
        // main erase from the top block, upper parameter block survives
        send_word(1'b1, 17'h00000, OP_ERASE_SETUP);
        main_erase_ok = 1'b1;
        send_word(1'b1, 17'h1F000, OP_ERASE_CONFIRM);
        send_word(1'b0, 17'h1FFFF, 8'h00);
        // unknown command latches, view untouched
        send_word(1'b1, 17'h00000, 8'h3C);
        send_word(1'b0, 17'h0D020, 8'h00);

        // --- random part ---
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            if (!hold_done && words_sent >= goal - 650) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && words_sent >= goal - 350) begin
                // sender goes quiet until every response is back
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (outstanding != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end

            r = $urandom_range(0, 99);
            if (r < 30) begin
                // program setup, data, usually a read back
                send_word(1'b1, ADDR_W'($urandom), OP_PROGRAM_SETUP);
                if ($urandom_range(0, 4) == 0) send_word(1'b0, pick_addr(), DATA_W'($urandom));
                a = pick_addr();
                send_word(1'b1, a, DATA_W'($urandom));
                if ($urandom_range(0, 9) < 6) send_word(1'b0, a, DATA_W'($urandom));
            end else if (r < 48) begin
                repeat ($urandom_range(1, 4)) send_word(1'b0, pick_addr(), DATA_W'($urandom));
            end else if (r < 62) begin
                // view switch and a few reads, array view favored
                case ($urandom_range(0, 5))
                    0:       cmd = OP_READ_ID;
                    1:       cmd = OP_READ_STATUS;
                    2:       cmd = OP_CLEAR_STATUS;
                    default: cmd = OP_READ_ARRAY;
                endcase
                send_word(1'b1, ADDR_W'($urandom), cmd);
                repeat ($urandom_range(1, 3)) send_word(1'b0, pick_addr(), DATA_W'($urandom));
            end else if (r < 72) begin
                send_word(1'b1, ADDR_W'($urandom), OP_ERASE_SETUP);
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    // broken sequence: most likely a byte other than the confirm
                    send_word(1'b1, ADDR_W'($urandom), DATA_W'($urandom));
                end else if (r < 33 && main_erases_left > 0) begin
                    main_erase_ok = 1'b1;
                    a = ($urandom_range(0, 1) == 1) ? ADDR_W'($urandom_range('h10000, 'h1FFFF))
                                                   : ADDR_W'($urandom_range(0, 'hBFFF));
                    send_word(1'b1, a, OP_ERASE_CONFIRM);
                end else begin
                    // parameter or boot block
                    case ($urandom_range(0, 3))
                        0:       a = PARAM0_BASE;
                        1:       a = PARAM1_BASE;
                        2:       a = BOOT_BASE;
                        default: a = BOOT_BASE | 17'h01000;
                    endcase
                    send_word(1'b1, a | ADDR_W'($urandom_range(0, 'hFFF)), OP_ERASE_CONFIRM);
                end
                if ($urandom_range(0, 1) == 1) send_word(1'b0, pick_addr(), DATA_W'($urandom));
            end else if (r < 88) begin
                // noise write, seven in sixteen of them a named command byte
                case ($urandom_range(0, 15))
                    0:       cmd = OP_READ_ARRAY;
                    1:       cmd = OP_READ_ID;
                    2:       cmd = OP_READ_STATUS;
                    3:       cmd = OP_CLEAR_STATUS;
                    4:       cmd = OP_ERASE_SETUP;
                    5:       cmd = OP_ERASE_CONFIRM;
                    6:       cmd = OP_PROGRAM_SETUP;
                    default: cmd = DATA_W'($urandom);
                endcase
                send_word(1'b1, ADDR_W'($urandom), cmd);
            end else begin
                send_word(1'b0, ADDR_W'($urandom), DATA_W'($urandom));
            end
        end

        // drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("boot_block_flash_command_interface_core test passed");
        end else begin
            $display("boot_block_flash_command_interface_core test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bbfci_pkg.sv
hw/rtl/boot_block_flash_command_interface_core.sv
tb/flash_bus_checker.sv
tb/tb_boot_block_flash_command_interface_core.sv
